/* rtl/spe_pkg.sv */
// Shared types and constants of the sinusoidal position encoder.
// Used by spe_mul, spe_div and the core top level; no dependencies.
`default_nettype none
package spe_pkg;

  localparam int MUL_W   = 32;  // serial multiplier operand width
  localparam int DIV_N_W = 44;  // serial divider dividend width
  localparam int DIV_D_W = 34;  // serial divider divisor width

  localparam logic [30:0] Q30_ONE        = 31'h4000_0000;
  localparam logic [29:0] LN2_Q30        = 30'd744261118;
  localparam logic [32:0] HALF_PI_Q30    = 33'd1686629713;
  localparam logic [32:0] TWO_PI_Q30     = 33'd6746518852;
  localparam logic [19:0] LOG2_10000_Q16 = 20'd870824;
  localparam logic [19:0] LOG2_1000_Q16  = 20'd653118;

  localparam logic [3:0] EXP_TERMS = 4'd12;
  localparam logic [3:0] SIN_TERMS = 4'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DISABLED = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_DIM    = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_X, S_Z, S_EM, S_ED, S_OFF, S_ANG, S_MOD, S_QUAD,
    S_SQ, S_SM, S_SD, S_SF, S_PUT
  } state_t;

  // Horner divisor (2j)(2j+1) of the sine series
  function automatic logic [7:0] sin_div(input logic [3:0] j);
    logic [7:0] d;
    case (j)
      4'd7:    d = 8'd210;
      4'd6:    d = 8'd156;
      4'd5:    d = 8'd110;
      4'd4:    d = 8'd72;
      4'd3:    d = 8'd42;
      4'd2:    d = 8'd20;
      default: d = 8'd6;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

/* rtl/spe_mul.sv */
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on spe_pkg for the operand width.
`default_nettype none
module spe_mul (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [spe_pkg::MUL_W-1:0]     a,
  input  wire logic [spe_pkg::MUL_W-1:0]     b,
  output logic                               done,
  output logic [2*spe_pkg::MUL_W-1:0]        prod
);
  localparam int W = spe_pkg::MUL_W;
  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [2*W-1:0] mcand;
  logic [W-1:0]  mplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      prod   <= '0;
      mcand  <= {{W{1'b0}}, a};
      mplier <= b;
    end else if (busy) begin
      if (mplier[0]) prod <= prod + mcand;
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end
endmodule
`default_nettype wire

/* rtl/spe_div.sv */
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on spe_pkg for the dividend and divisor widths.
`default_nettype none
module spe_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [spe_pkg::DIV_N_W-1:0]   num,
  input  wire logic [spe_pkg::DIV_D_W-1:0]   den,
  output logic                               done,
  output logic [spe_pkg::DIV_N_W-1:0]        quo,
  output logic [spe_pkg::DIV_D_W-1:0]        rem
);
  localparam int NW = spe_pkg::DIV_N_W;
  localparam int DW = spe_pkg::DIV_D_W;
  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] dvs;
  logic [DW:0]   trial;
  logic          fits;

  always_comb begin
    trial = {rem, quo[NW-1]};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rem <= '0;
      quo <= num;
      dvs <= den;
    end else if (busy) begin
      rem <= fits ? DW'(trial - {1'b0, dvs}) : DW'(trial);
      quo <= {quo[NW-2:0], fits};
    end
  end
endmodule
`default_nettype wire

/* rtl/sinusoidal_position_encoder_core.sv */
// Sinusoidal position encoder core; depends on spe_pkg, spe_mul and spe_div.
// Each value takes 23 multiplier passes and 21 divider passes (22 in mode 1),
// a quadrant step and an output step.
// An item is accepted in the idle state and then yields dim values; an error item yields one.
// Output stalls hold the core in its output step; one item is in flight at a time.
// Synchronous reset clears control and config (disabled, dim 64, mode 0).
`default_nettype none
module sinusoidal_position_encoder_core #(
  parameter int MAX_DIM      = 64,
  parameter int BUFFER_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // position[9:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // status[1:0], dim_index[7:2], value[23:8]
  output logic             m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [6:0]  cfg_data
);
  localparam int IW  = $clog2(MAX_DIM);
  localparam int DMW = $clog2(MAX_DIM + 1);
  localparam int MW  = spe_pkg::MUL_W;
  localparam int NW  = spe_pkg::DIV_N_W;
  localparam int DW  = spe_pkg::DIV_D_W;

  logic       encoding_enable;
  logic [6:0] dim_cfg;
  logic       frequency_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      encoding_enable <= 1'b0;
      dim_cfg         <= 7'd64;
      frequency_mode  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spe_pkg::REG_ENABLE: encoding_enable <= cfg_data[0];
        spe_pkg::REG_DIM:    dim_cfg         <= cfg_data;
        spe_pkg::REG_MODE:   frequency_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  spe_pkg::state_t state, state_next;
  logic          pend;
  logic [IW-1:0] idx;
  logic [DMW-1:0] dim;
  logic [9:0]    pos;
  logic          mode;
  logic [1:0]    err;
  logic [3:0]    n;
  logic [15:0]   f;
  logic [29:0]   z;
  logic [30:0]   r;
  logic [3:0]    cnt;
  logic [32:0]   t;
  logic [15:0]   off;
  logic [NW-1:0] a;
  logic [32:0]   arem;
  logic [1:0]    quad;
  logic [31:0]   u;
  logic [31:0]   u2;
  logic [31:0]   s;

  logic          out_load;
  logic          mul_start, div_start, mul_done, div_done;
  logic [MW-1:0] mul_a, mul_b;
  logic [2*MW-1:0] prod;
  logic [NW-1:0] div_n, quo;
  logic [DW-1:0] div_d, rem;

  logic [DMW-1:0] dim_eff;
  logic [IW-1:0]  ek;
  logic [19:0]    log2_base;
  logic           is_last;
  logic [31:0]    p;
  logic [1:0]     q_c;
  logic [32:0]    u_c;
  logic [15:0]    mag;

  always_comb begin
    if (dim_cfg == 7'd0 || 32'(dim_cfg) > MAX_DIM) dim_eff = DMW'(MAX_DIM);
    else dim_eff = DMW'(dim_cfg);
    ek        = idx & ~IW'(1);
    log2_base = mode ? spe_pkg::LOG2_1000_Q16 : spe_pkg::LOG2_10000_Q16;
    is_last   = (DMW'(idx) + DMW'(1)) == dim;
    p         = 32'({pos, 16'd0}) + 32'(off);
    mag       = 16'((s + 32'h8000) >> 16);
    if (arem >= 33'(3 * spe_pkg::HALF_PI_Q30)) q_c = 2'd3;
    else if (arem >= 33'(2 * spe_pkg::HALF_PI_Q30)) q_c = 2'd2;
    else if (arem >= spe_pkg::HALF_PI_Q30) q_c = 2'd1;
    else q_c = 2'd0;
    u_c = arem - 33'(q_c * spe_pkg::HALF_PI_Q30);
    if (q_c[0]) u_c = spe_pkg::HALF_PI_Q30 - u_c;
  end

  // operand selection for the shared serial units
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_n = '0;
    div_d = DW'(1);
    case (state)
      spe_pkg::S_X: begin
        div_n = NW'(ek * log2_base);
        div_d = DW'(dim);
      end
      spe_pkg::S_Z:   begin mul_a = MW'(f); mul_b = MW'(spe_pkg::LN2_Q30); end
      spe_pkg::S_EM:  begin mul_a = MW'(z); mul_b = MW'(r); end
      spe_pkg::S_ED:  begin div_n = NW'(t); div_d = DW'(cnt); end
      spe_pkg::S_OFF: begin
        div_n = NW'(DMW'(idx) + DMW'(1)) << 15;
        div_d = DW'(dim);
      end
      spe_pkg::S_ANG: begin mul_a = p; mul_b = MW'(r >> n); end
      spe_pkg::S_MOD: begin div_n = a; div_d = DW'(spe_pkg::TWO_PI_Q30); end
      spe_pkg::S_SQ:  begin mul_a = u; mul_b = u; end
      spe_pkg::S_SM:  begin mul_a = u2; mul_b = MW'(r); end
      spe_pkg::S_SD:  begin div_n = NW'(t); div_d = DW'(spe_pkg::sin_div(cnt)); end
      spe_pkg::S_SF:  begin mul_a = u; mul_b = MW'(r); end
      default: ;
    endcase
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    mul_start     = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      spe_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (!encoding_enable || {1'b0, s_axis_tdata[9:0]} >= 11'(BUFFER_DEPTH))
            state_next = spe_pkg::S_PUT;
          else state_next = spe_pkg::S_X;
        end
      end
      spe_pkg::S_X, spe_pkg::S_ED, spe_pkg::S_OFF, spe_pkg::S_MOD, spe_pkg::S_SD: begin
        div_start = !pend;
        if (div_done) begin
          unique case (state)
            spe_pkg::S_X:   state_next = spe_pkg::S_Z;
            spe_pkg::S_ED:
              if (cnt == 4'd1) state_next = mode ? spe_pkg::S_OFF : spe_pkg::S_ANG;
              else state_next = spe_pkg::S_EM;
            spe_pkg::S_OFF: state_next = spe_pkg::S_ANG;
            spe_pkg::S_MOD: state_next = spe_pkg::S_QUAD;
            default:
              if (cnt == 4'd1) state_next = spe_pkg::S_SF;
              else state_next = spe_pkg::S_SM;
          endcase
        end
      end
      spe_pkg::S_Z, spe_pkg::S_EM, spe_pkg::S_ANG, spe_pkg::S_SQ, spe_pkg::S_SM,
      spe_pkg::S_SF: begin
        mul_start = !pend;
        if (mul_done) begin
          unique case (state)
            spe_pkg::S_Z:   state_next = spe_pkg::S_EM;
            spe_pkg::S_EM:  state_next = spe_pkg::S_ED;
            spe_pkg::S_ANG: state_next = spe_pkg::S_MOD;
            spe_pkg::S_SQ:  state_next = spe_pkg::S_SM;
            spe_pkg::S_SM:  state_next = spe_pkg::S_SD;
            default:        state_next = spe_pkg::S_PUT;
          endcase
        end
      end
      spe_pkg::S_QUAD: state_next = spe_pkg::S_SQ;
      spe_pkg::S_PUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load = 1'b1;
          if (err != spe_pkg::ST_OK || is_last) state_next = spe_pkg::S_IDLE;
          else state_next = spe_pkg::S_X;
        end
      end
      default: state_next = spe_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spe_pkg::S_IDLE;
      pend  <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state_next != state) ? 1'b0 : (pend | mul_start | div_start);
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tlast <= (err != spe_pkg::ST_OK) || is_last;
      if (err != spe_pkg::ST_OK) m_axis_tdata <= {16'd0, 6'd0, err};
      else m_axis_tdata <= {(quad[1] ? -mag : mag), 6'(idx), spe_pkg::ST_OK};
      idx <= idx + IW'(1);
    end
    case (state)
      spe_pkg::S_IDLE: begin
        pos  <= s_axis_tdata[9:0];
        mode <= frequency_mode;
        dim  <= dim_eff;
        idx  <= '0;
        if (!encoding_enable) err <= spe_pkg::ST_DISABLED;
        else if ({1'b0, s_axis_tdata[9:0]} >= 11'(BUFFER_DEPTH)) err <= spe_pkg::ST_RANGE;
        else err <= spe_pkg::ST_OK;
      end
      spe_pkg::S_X: if (div_done) begin
        n <= quo[19:16];
        f <= quo[15:0];
      end
      spe_pkg::S_Z: if (mul_done) begin
        z   <= prod[45:16];
        r   <= spe_pkg::Q30_ONE;
        cnt <= spe_pkg::EXP_TERMS;
        off <= '0;
      end
      spe_pkg::S_EM, spe_pkg::S_SM: if (mul_done) t <= prod[62:30];
      spe_pkg::S_ED, spe_pkg::S_SD: if (div_done) begin
        r   <= spe_pkg::Q30_ONE - quo[30:0];
        cnt <= cnt - 4'd1;
      end
      spe_pkg::S_OFF: if (div_done) off <= quo[15:0];
      spe_pkg::S_ANG: if (mul_done)
        a <= NW'(prod[56:16]) + (idx[0] ? NW'(spe_pkg::HALF_PI_Q30) : NW'(0));
      spe_pkg::S_MOD: if (div_done) arem <= rem[32:0];
      spe_pkg::S_QUAD: begin
        quad <= q_c;
        u    <= 32'(u_c);
      end
      spe_pkg::S_SQ: if (mul_done) begin
        u2  <= prod[61:30];
        r   <= spe_pkg::Q30_ONE;
        cnt <= spe_pkg::SIN_TERMS;
      end
      spe_pkg::S_SF: if (mul_done) s <= prod[61:30];
      default: ;
    endcase
  end

  spe_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(prod)
  );

  spe_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_n), .den(div_d),
    .done(div_done), .quo(quo), .rem(rem)
  );
endmodule
`default_nettype wire
